// File: rtl/b64e_pkg.sv
// Shared types, constants and the alphabet lookup for the base-64 stream encoder.
// Used by every module of the block; depends on nothing else.
package b64e_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] LINE_CHARS_RESET = 8'd76;
	localparam logic [7:0] PAD_CHAR         = 8'h3D;
	localparam logic [7:0] CR_CHAR          = 8'h0D;
	localparam logic [7:0] LF_CHAR          = 8'h0A;

	// One classified request from the front end: a group of cnt bytes (0 means no
	// group, which only happens on an empty end) and the end-of-message flag.
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [1:0] cnt;
		logic       last;
	} cmd_t;

	function automatic logic [7:0] digit(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26) begin
			return 8'h41 + w;
		end else if (v < 6'd52) begin
			return 8'h61 + w - 8'd26;
		end else if (v < 6'd62) begin
			return 8'h30 + w - 8'd52;
		end else if (v == 6'd62) begin
			return 8'h2B;
		end else begin
			return 8'h2F;
		end
	endfunction

endpackage

// File: rtl/b64e_front.sv
// Front end: accepts message bytes, gathers them into groups of three and pushes
// one request per group or message end into the queue. Depends on b64e_pkg.
module b64e_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [7:0]       s_axis_tdata,  // [7:0] data_byte
	input  logic [0:0]       s_axis_tuser,  // [0] byte_valid
	input  logic             s_axis_tlast,
	input  logic             queue_full,
	output logic             push,
	output b64e_pkg::cmd_t   cmd
);

	logic [1:0] held_count_q;
	logic [7:0] held0_q;
	logic [7:0] held1_q;
	logic [1:0] n_count;
	logic [7:0] n_h0;
	logic [7:0] n_h1;
	logic       want_push;
	logic       full_group;
	logic       accept;

	assign s_axis_tready = !queue_full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign push          = accept && want_push;
	assign full_group    = s_axis_tuser[0] && (held_count_q == 2'd2);

	always_comb begin
		cmd       = '0;
		want_push = 1'b0;
		n_count   = held_count_q;
		n_h0      = held0_q;
		n_h1      = held1_q;
		if (s_axis_tuser[0]) begin
			if (held_count_q == 2'd2) begin
				cmd.b0    = held0_q;
				cmd.b1    = held1_q;
				cmd.b2    = s_axis_tdata;
				cmd.cnt   = 2'd3;
				want_push = 1'b1;
				n_count   = 2'd0;
			end else if (held_count_q == 2'd1) begin
				n_h1    = s_axis_tdata;
				n_count = 2'd2;
			end else begin
				n_h0    = s_axis_tdata;
				n_count = 2'd1;
			end
		end
		if (s_axis_tlast) begin
			want_push = 1'b1;
			cmd.last  = 1'b1;
			// A partial group is flushed with the missing bytes read as zero.
			if (!full_group) begin
				cmd.cnt = n_count;
				cmd.b0  = n_h0;
				cmd.b1  = (n_count == 2'd2) ? n_h1 : 8'h00;
				cmd.b2  = 8'h00;
			end
			n_count = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= 2'd0;
		end else if (accept) begin
			held_count_q <= n_count;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held0_q <= n_h0;
			held1_q <= n_h1;
		end
	end

endmodule

// File: rtl/b64e_queue.sv
// Short request queue in flip-flops between the front end and the back end.
// Depends on b64e_pkg for the request type and depth.
module b64e_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  b64e_pkg::cmd_t   wr_cmd,
	input  logic             pop,
	output b64e_pkg::cmd_t   head,
	output logic             full,
	output logic             empty
);

	b64e_pkg::cmd_t                   mem_q [b64e_pkg::QUEUE_DEPTH];
	logic [b64e_pkg::QUEUE_AW-1:0]    wr_ptr_q;
	logic [b64e_pkg::QUEUE_AW-1:0]    rd_ptr_q;
	logic [b64e_pkg::QUEUE_AW:0]      count_q;

	assign full  = (count_q == (b64e_pkg::QUEUE_AW+1)'(b64e_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (b64e_pkg::QUEUE_AW+1)'(b64e_pkg::QUEUE_DEPTH))
		else $error("queue count above depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue popped while empty");
`endif

endmodule

// File: rtl/b64e_back.sv
// Back end: steps each queued request into the output register, one character
// a cycle unless stalled, CR LF when the line is full. Depends on b64e_pkg.
module b64e_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       line_chars,
	input  b64e_pkg::cmd_t   head,
	input  logic             empty,
	output logic             pop,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // [7:0] out_char
	output logic [1:0]       m_axis_tuser,  // [0] char_valid, [1] message_end
	output logic             m_axis_tlast
);

	localparam logic [2:0] ST_CR    = 3'd0;
	localparam logic [2:0] ST_LF    = 3'd1;
	localparam logic [2:0] ST_D0    = 3'd2;
	localparam logic [2:0] ST_D1    = 3'd3;
	localparam logic [2:0] ST_D2    = 3'd4;
	localparam logic [2:0] ST_D3    = 3'd5;
	localparam logic [2:0] ST_EMPTY = 3'd6;

	logic       active_q;
	logic [2:0] step_q;
	logic [7:0] col_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       out_cv_q;
	logic       out_last_q;
	logic       out_end_q;

	logic       wrap;
	logic [2:0] start_step;
	logic [2:0] cur_step;
	logic       final_step;
	logic       load_ok;
	logic       emit;
	logic [7:0] chr;
	logic [8:0] col_sum;

	assign wrap       = (line_chars != 8'd0) && (col_q >= line_chars);
	assign start_step = (head.cnt == 2'd0) ? ST_EMPTY : (wrap ? ST_CR : ST_D0);
	assign cur_step   = active_q ? step_q : start_step;
	assign final_step = (cur_step == ST_D3) || (cur_step == ST_EMPTY);
	assign load_ok    = !out_valid_q || m_axis_tready;
	assign emit       = load_ok && !empty;
	assign pop        = emit && final_step;
	assign col_sum    = {1'b0, col_q} + 9'd4;

	always_comb begin
		unique case (cur_step)
			ST_CR:   chr = b64e_pkg::CR_CHAR;
			ST_LF:   chr = b64e_pkg::LF_CHAR;
			ST_D0:   chr = b64e_pkg::digit(head.b0[7:2]);
			ST_D1:   chr = b64e_pkg::digit({head.b0[1:0], head.b1[7:4]});
			ST_D2:   chr = (head.cnt > 2'd1) ?
				b64e_pkg::digit({head.b1[3:0], head.b2[7:6]}) : b64e_pkg::PAD_CHAR;
			ST_D3:   chr = (head.cnt > 2'd2) ?
				b64e_pkg::digit(head.b2[5:0]) : b64e_pkg::PAD_CHAR;
			default: chr = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			step_q      <= ST_CR;
			col_q       <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_ok) begin
				out_valid_q <= emit;
			end
			if (emit) begin
				if (final_step) begin
					active_q <= 1'b0;
				end else begin
					active_q <= 1'b1;
					step_q   <= cur_step + 3'd1;
				end
				// The column restarts after CR and at every message end.
				if (cur_step == ST_CR || cur_step == ST_EMPTY) begin
					col_q <= 8'd0;
				end else if (cur_step == ST_D3) begin
					if (head.last) begin
						col_q <= 8'd0;
					end else begin
						col_q <= col_sum[8] ? 8'hFF : col_sum[7:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q <= chr;
			out_cv_q   <= (cur_step != ST_EMPTY);
			out_last_q <= final_step;
			out_end_q  <= final_step && head.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_char_q;
	assign m_axis_tuser  = {out_end_q, out_cv_q};
	assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_cr_then_lf: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && cur_step == ST_CR) |=> (active_q && step_q == ST_LF))
		else $error("CR not followed by LF");
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tlast)
		else $error("message end without run last");
`endif

endmodule

// File: rtl/base64_stream_encoder_top.sv
// Base-64 stream encoder: a byte is taken at most once a cycle; the first character
// of a request goes through the queue and then the back-end output register.
// Characters leave one per cycle from the back-end output register while the
// receiver is ready; a full group gives four characters, or six when CR LF goes
// before it; a four-entry queue lets a byte enter while characters drain.
// Reset is asynchronous: queue, byte count and column clear, line_chars is 76.
module base64_stream_encoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic [0:0] s_axis_tuser,   // [0] byte_valid
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_char
	output logic [1:0] m_axis_tuser,   // [0] char_valid, [1] message_end
	output logic       m_axis_tlast,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data        // [7:0] line_chars
);

	logic           line_chars_q;
	logic [7:0]     line_chars_r_q;
	logic           push;
	logic           pop;
	logic           full;
	logic           empty;
	b64e_pkg::cmd_t wr_cmd;
	b64e_pkg::cmd_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_chars_r_q <= b64e_pkg::LINE_CHARS_RESET;
			line_chars_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			line_chars_r_q <= cfg_data;
			line_chars_q   <= 1'b1;
		end
	end

	b64e_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.queue_full    (full),
		.push          (push),
		.cmd           (wr_cmd)
	);

	b64e_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.head   (head),
		.full   (full),
		.empty  (empty)
	);

	b64e_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.line_chars    (line_chars_q ? line_chars_r_q : b64e_pkg::LINE_CHARS_RESET),
		.head          (head),
		.empty         (empty),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// File: sim/tb_base64_stream_encoder_top.sv
// Self-checking testbench for base64_stream_encoder_top: byte requests in, characters out.
// Depends on rtl/b64e_pkg.sv and rtl/base64_stream_encoder_top.sv.
`timescale 1ns / 100ps

typedef struct packed {
	logic [7:0] ch;
	logic       ch_valid;
	logic       run_end;
	logic       msg_end;
} char_rec_t;

// Tracks encoder state in parallel with the block and holds the characters still owed.
class b64_char_board;
	string      alphabet;
	logic [7:0] line_chars;
	logic [7:0] held_bytes [2];
	int         held_count;
	int         line_column;
	int         mismatches;
	int         chars_seen;
	char_rec_t  expected_chars [$];
	char_rec_t  step_chars [$];

	function new();
		alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
		line_chars = b64e_pkg::LINE_CHARS_RESET;
		held_count = 0;
		line_column = 0;
		mismatches = 0;
		chars_seen = 0;
	endfunction

	function void push_char(logic [7:0] c);
		char_rec_t r;
		r = '{c, 1'b1, 1'b0, 1'b0};
		step_chars.push_back(r);
	endfunction

	function logic [7:0] digit_of(logic [5:0] v);
		return alphabet[int'(v)];
	endfunction

	// Unused trailing bytes must be passed as zero.
	function void encode_group(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, int cnt);
		if (line_chars != 0 && line_column >= line_chars) begin
			push_char(b64e_pkg::CR_CHAR);
			push_char(b64e_pkg::LF_CHAR);
			line_column = 0;
		end
		push_char(digit_of(b0[7:2]));
		push_char(digit_of({b0[1:0], b1[7:4]}));
		push_char(cnt > 1 ? digit_of({b1[3:0], b2[7:6]}) : b64e_pkg::PAD_CHAR);
		push_char(cnt > 2 ? digit_of(b2[5:0]) : b64e_pkg::PAD_CHAR);
		line_column = (line_column + 4 > 255) ? 255 : line_column + 4;
	endfunction

	function void note_byte_request(logic [7:0] data, logic byte_valid, logic msg_last);
		char_rec_t r;
		step_chars.delete();
		if (byte_valid) begin
			if (held_count == 2) begin
				encode_group(held_bytes[0], held_bytes[1], data, 3);
				held_count = 0;
			end else begin
				held_bytes[held_count] = data;
				held_count++;
			end
		end
		if (msg_last) begin
			if (held_count == 1)
				encode_group(held_bytes[0], 8'h00, 8'h00, 1);
			else if (held_count == 2)
				encode_group(held_bytes[0], held_bytes[1], 8'h00, 2);
			held_count = 0;
			line_column = 0;
			// An end with nothing to flush still produces one empty marker.
			if (step_chars.size() == 0) begin
				r = '{8'h00, 1'b0, 1'b0, 1'b0};
				step_chars.push_back(r);
			end
		end
		if (step_chars.size() != 0) begin
			r = step_chars.pop_back();
			r.run_end = 1'b1;
			r.msg_end = msg_last;
			step_chars.push_back(r);
		end
		foreach (step_chars[i])
			expected_chars.push_back(step_chars[i]);
	endfunction

	function void check_char(logic [7:0] ch, logic ch_valid, logic run_end, logic msg_end);
		char_rec_t want;
		chars_seen++;
		if (expected_chars.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("char %0d: none expected, got ch=%02h v=%0d last=%0d end=%0d",
					chars_seen, ch, ch_valid, run_end, msg_end);
			return;
		end
		want = expected_chars.pop_front();
		if (want.ch !== ch || want.ch_valid !== ch_valid || want.run_end !== run_end ||
				want.msg_end !== msg_end) begin
			mismatches++;
			if (mismatches <= 10)
				$display("char %0d: want %02h/%0d/%0d/%0d got %02h/%0d/%0d/%0d",
					chars_seen, want.ch, want.ch_valid, want.run_end, want.msg_end,
					ch, ch_valid, run_end, msg_end);
		end
	endfunction
endclass

module tb_base64_stream_encoder_top;

	localparam int IDLE_LIMIT  = 4000;
	localparam int HOLD_CYCLES = 400;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic [0:0] s_axis_tuser = 1'b0;
	logic       s_axis_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic       m_axis_tlast;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = 8'h00;

	b64_char_board board;
	int            burst_left = 0;
	bit            hold_off_req = 1'b0;
	int            idle_cycles = 0;

	base64_stream_encoder_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				board.note_byte_request(s_axis_tdata, s_axis_tuser[0], s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				board.check_char(m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]);
			if (cfg_valid && cfg_ready)
				board.line_chars = cfg_data;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("base64_stream_encoder_top: mismatch");
				$finish;
			end
		end
	end

	// Receiver: the stall pattern is redrawn at random intervals; one long hold-off on request.
	initial begin
		int mode;
		int span;
		int tick;
		tick = 0;
		@(posedge clk);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(16, 96);
			repeat (span) begin
				if (hold_off_req) begin
					m_axis_tready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
					hold_off_req = 1'b0;
				end
				case (mode)
					0: begin
						m_axis_tready <= 1'b1;
					end
					1: begin
						m_axis_tready <= $urandom_range(0, 1);
					end
					2: begin
						m_axis_tready <= ($urandom_range(0, 3) == 0);
					end
					default: begin
						m_axis_tready <= (tick % 3 != 0);
					end
				endcase
				tick++;
				@(posedge clk);
			end
		end
	end

	task automatic send_item(input logic [7:0] data, input logic byte_valid, input logic msg_last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		s_axis_tuser <= byte_valid;
		s_axis_tlast <= msg_last;
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
	endtask

	// A message of len bytes; the end rides on the last byte or on a bare end marker.
	task automatic send_message(input int len, input bit bare_end);
		bit bare;
		bare = bare_end || (len == 0);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_item(8'($urandom_range(0, 255)), 1'b1, !bare && (i == len - 1));
		end
		if (bare)
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	task automatic drain_chars(input int settle);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (board.expected_chars.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_line_chars(input logic [7:0] value);
		drain_chars(8);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random_phase(input int target);
		int count;
		int len;
		bit bare;
		count = 0;
		while (count < target) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 16);
			bare = ($urandom_range(0, 3) == 0);
			send_message(len, bare);
			count += len + ((bare || len == 0) ? 1 : 0);
		end
	endtask

	initial begin
		board = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset line length.
		send_item(8'hA5, 1'b0, 1'b1);   // empty message
		send_item(8'h3C, 1'b0, 1'b0);   // no byte, no end
		send_item(8'h00, 1'b1, 1'b1);   // single byte, two pads
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'hFF, 1'b1, 1'b1);   // two bytes, one pad
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'h10, 1'b1, 1'b0);
		send_item(8'h83, 1'b1, 1'b1);   // full group ending the message
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);   // bare end after a complete group
		send_item(8'h4D, 1'b1, 1'b0);
		send_item(8'h7E, 1'b0, 1'b1);   // bare end flushes one held byte
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h5A, 1'b0, 1'b1);   // bare end flushes two held bytes

		// Wrap after every group.
		write_line_chars(8'd4);
		for (int i = 0; i < 7; i++)
			send_item(8'(8'h30 + i), 1'b1, i == 6);

		write_line_chars(8'd0);
		run_random_phase(30);

		// Longest line, with the receiver held off so the input side backs up.
		write_line_chars(8'd252);
		hold_off_req = 1'b1;
		send_message(140, 1'b0);

		write_line_chars(8'd1);
		run_random_phase(30);
		write_line_chars(8'd3);
		run_random_phase(25);
		write_line_chars(8'($urandom_range(2, 251)));
		run_random_phase(30);

		drain_chars(20);
		if (board.mismatches == 0 && board.expected_chars.size() == 0)
			$display("base64_stream_encoder_top: match");
		else
			$display("base64_stream_encoder_top: mismatch");
		$finish;
	end

endmodule

// File: sim.f
rtl/b64e_pkg.sv
rtl/b64e_front.sv
rtl/b64e_queue.sv
rtl/b64e_back.sv
rtl/base64_stream_encoder_top.sv
sim/tb_base64_stream_encoder_top.sv
